>>> hdl/rpr_pkg.sv
// Constants and helper types for the rotary pair rotation unit.
package rpr_pkg;

    localparam int unsigned TWO_PI  = 6283;
    localparam int unsigned PI_MR   = 3142;
    localparam int unsigned HALF_PI = 1571;

    // Reciprocals for exact division by constants: q = (x * M) >> K.
    localparam int unsigned K_POS  = 33;
    localparam int unsigned K_RATE = 29;
    localparam int unsigned K_PM   = 39;
    localparam int unsigned K_HI   = 26;
    localparam int unsigned K_LO   = 34;

    localparam logic [20:0] M_POS  = 21'(((64'd1 << K_POS)  + 64'd6282) / 64'd6283);
    localparam logic [16:0] M_RATE = 17'(((64'd1 << K_RATE) + 64'd6282) / 64'd6283);
    localparam logic [26:0] M_PM   = 27'(((64'd1 << K_PM)   + 64'd6282) / 64'd6283);
    localparam logic [19:0] M_HI   = 20'(((64'd1 << K_HI)   + 64'd124) / 64'd125);
    localparam logic [27:0] M_LO   = 28'(((64'd1 << K_LO)   + 64'd124) / 64'd125);

    // Bhaskara kernel constants
    localparam logic [35:0] NUM_SCALE = 36'd16000;
    localparam logic [25:0] DEN_BASE  = 26'd49360820;

    localparam int unsigned DIV_BITS = 11;

    typedef struct packed {
        logic        neg;
        logic [10:0] x;
    } fold_t;

endpackage

>>> hdl/rotary_pair_rotation_unit.sv
// Rotary pair rotation unit: rotates a pair of x1000 values by position*rate mrad.
//
// Streaming rotator, one pair per cycle unless the output is held. The angle
// position*rate_mrad is reduced modulo 6283 from the residues of its two
// factors, sine and cosine come from the Bhaskara I kernel (cosine is sine of
// angle+1571) through an 11-stage restoring divider, one quotient bit a stage,
// and the rotated pair is divided by 1000 with truncation toward zero. The
// whole pipeline advances together: when a result sits at the output and
// out_ready is low, every stage holds and in_ready drops in the same cycle, so
// throughput is one transfer per cycle whenever the consumer keeps up. Items are
// independent; there is no state between them and nothing to clear after reset.
module rotary_pair_rotation_unit
    import rpr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [19:0]        position,
    input  logic [15:0]        rate_mrad,
    input  logic signed [31:0] first_value,
    input  logic signed [31:0] second_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [33:0] rotated_first,
    output logic signed [33:0] rotated_second
);

    localparam int NST   = 26;   // pipeline depth
    localparam int X_LEN = 20;   // pair delay up to the multiply stage

    logic en;
    logic [NST-1:0] vld_reg;

    // Global advance: the pipeline moves unless the output is held.
    assign en        = !vld_reg[NST-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // Pair values ride alongside the angle path.
    logic signed [31:0] x0_pipe_reg [X_LEN];
    logic signed [31:0] x1_pipe_reg [X_LEN];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_pipe_reg[0] <= first_value;
            x1_pipe_reg[0] <= second_value;
            for (int i = 1; i < X_LEN; i++)
            begin
                x0_pipe_reg[i] <= x0_pipe_reg[i-1];
                x1_pipe_reg[i] <= x1_pipe_reg[i-1];
            end
        end
    end

    // ---------------- angle reduction ----------------
    // Stage 1: quotients of each factor by 6283.
    logic [40:0] pos_prod;
    logic [32:0] rate_prod;
    logic [19:0] pos1_reg;
    logic [15:0] rate1_reg;
    logic [7:0]  pq1_reg;
    logic [3:0]  rq1_reg;

    assign pos_prod  = 41'(position) * 41'(M_POS);
    assign rate_prod = 33'(rate_mrad) * 33'(M_RATE);

    // Stage 2: residues of each factor.
    logic [19:0] pos_rem;
    logic [15:0] rate_rem;
    logic [12:0] pr2_reg;
    logic [12:0] rr2_reg;

    assign pos_rem  = pos1_reg - 20'(pq1_reg) * 20'(TWO_PI);
    assign rate_rem = rate1_reg - 16'(rq1_reg) * 16'(TWO_PI);

    // Stage 3: product of residues; stage 4: its quotient; stage 5: angle.
    logic [25:0] pm3_reg;
    logic [25:0] pm4_reg;
    logic [52:0] pm_prod;
    logic [12:0] mq4_reg;
    logic [25:0] a_full;
    logic [12:0] a5_reg;

    assign pm_prod = 53'(pm3_reg) * 53'(M_PM);
    assign a_full  = pm4_reg - 26'(mq4_reg) * 26'(TWO_PI);

    // Stage 6: sine angle and cosine angle (shifted a quarter turn).
    logic [13:0] ac_sum;
    logic [12:0] a6_reg;
    logic [12:0] ac6_reg;

    assign ac_sum = 14'(a5_reg) + 14'(HALF_PI);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos1_reg  <= position;
            rate1_reg <= rate_mrad;
            pq1_reg   <= pos_prod[K_POS +: 8];
            rq1_reg   <= rate_prod[K_RATE +: 4];
            pr2_reg   <= pos_rem[12:0];
            rr2_reg   <= rate_rem[12:0];
            pm3_reg   <= 26'(pr2_reg) * 26'(rr2_reg);
            pm4_reg   <= pm3_reg;
            mq4_reg   <= pm_prod[K_PM +: 13];
            a5_reg    <= a_full[12:0];
            a6_reg    <= a5_reg;
            ac6_reg   <= (ac_sum >= 14'(TWO_PI)) ? 13'(ac_sum - 14'(TWO_PI)) : ac_sum[12:0];
        end
    end

    // ---------------- quadrant fold and kernel ----------------
    function automatic fold_t fold_angle(input logic [12:0] a);
        fold_t f;
        if (a <= 13'(HALF_PI))
        begin
            f.neg = 1'b0;
            f.x   = a[10:0];
        end
        else if (a <= 13'(PI_MR))
        begin
            f.neg = 1'b0;
            f.x   = 11'(13'(PI_MR) - a);
        end
        else if (a <= 13'(PI_MR + HALF_PI))
        begin
            f.neg = 1'b1;
            f.x   = 11'(a - 13'(PI_MR));
        end
        else
        begin
            f.neg = 1'b1;
            f.x   = 11'(13'(TWO_PI) - a);
        end
        return f;
    endfunction

    // Lane 0 is sine, lane 1 is cosine.
    fold_t       f7_reg  [2];
    logic [21:0] px8_reg [2];
    logic        neg8_reg [2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f7_reg[0] <= fold_angle(a6_reg);
            f7_reg[1] <= fold_angle(ac6_reg);
            for (int l = 0; l < 2; l++)
            begin
                px8_reg[l]  <= 22'(f7_reg[l].x) * (22'(PI_MR) - 22'(f7_reg[l].x));
                neg8_reg[l] <= f7_reg[l].neg;
            end
        end
    end

    // ---------------- restoring divider, one bit a stage ----------------
    logic [36:0]         dv_rem_reg [DIV_BITS+1][2];
    logic [25:0]         dv_den_reg [DIV_BITS+1][2];
    logic [DIV_BITS-1:0] dv_q_reg   [DIV_BITS+1][2];
    logic                dv_neg_reg [DIV_BITS+1][2];

    // Stage 9: numerator and denominator of the kernel.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                dv_rem_reg[0][l] <= 37'(36'(px8_reg[l]) * NUM_SCALE);
                dv_den_reg[0][l] <= DEN_BASE - 26'({px8_reg[l], 2'b00});
                dv_q_reg[0][l]   <= '0;
                dv_neg_reg[0][l] <= neg8_reg[l];
            end
        end
    end

    for (genvar i = 1; i <= DIV_BITS; i++)
    begin : g_div
        localparam int BIT = DIV_BITS - i;
        logic [37:0] trial [2];

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                trial[l] = {1'b0, dv_rem_reg[i-1][l]} - (38'(dv_den_reg[i-1][l]) << BIT);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 2; l++)
                begin
                    dv_den_reg[i][l] <= dv_den_reg[i-1][l];
                    dv_neg_reg[i][l] <= dv_neg_reg[i-1][l];
                    if (!trial[l][37])
                    begin
                        dv_rem_reg[i][l]    <= trial[l][36:0];
                        dv_q_reg[i][l]      <= dv_q_reg[i-1][l] | (DIV_BITS'(1) << BIT);
                    end
                    else
                    begin
                        dv_rem_reg[i][l]    <= dv_rem_reg[i-1][l];
                        dv_q_reg[i][l]      <= dv_q_reg[i-1][l];
                    end
                end
            end
        end
    end

    // ---------------- rotation ----------------
    logic signed [11:0] sc [2];   // signed sine / cosine
    logic signed [43:0] x0_se;
    logic signed [43:0] x1_se;
    logic signed [43:0] sin_se;
    logic signed [43:0] cos_se;
    logic signed [43:0] p21_reg [4];
    logic signed [43:0] t22_reg [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            sc[l] = dv_neg_reg[DIV_BITS][l] ? -$signed({1'b0, dv_q_reg[DIV_BITS][l]})
                                            :  $signed({1'b0, dv_q_reg[DIV_BITS][l]});
        end
    end

    assign x0_se  = 44'(x0_pipe_reg[X_LEN-1]);
    assign x1_se  = 44'(x1_pipe_reg[X_LEN-1]);
    assign sin_se = 44'(sc[0]);
    assign cos_se = 44'(sc[1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p21_reg[0] <= x0_se * cos_se;
            p21_reg[1] <= x1_se * sin_se;
            p21_reg[2] <= x0_se * sin_se;
            p21_reg[3] <= x1_se * cos_se;
            t22_reg[0] <= p21_reg[0] - p21_reg[1];
            t22_reg[1] <= p21_reg[2] + p21_reg[3];
        end
    end

    // ---------------- divide by 1000, toward zero ----------------
    // |t| >> 3, then by 125 in two pieces: high 19 bits, then remainder with low 20.
    logic [43:0] mag     [2];
    logic [38:0] hi_prod [2];
    logic [54:0] lo_prod [2];
    logic [6:0]  rh      [2];
    logic [32:0] q_sum   [2];
    logic        neg23_reg [2];
    logic        neg24_reg [2];
    logic        neg25_reg [2];
    logic [18:0] xh23_reg  [2];
    logic [19:0] xl23_reg  [2];
    logic [12:0] qh23_reg  [2];
    logic [12:0] qh24_reg  [2];
    logic [12:0] qh25_reg  [2];
    logic [26:0] y24_reg   [2];
    logic [19:0] qy25_reg  [2];
    logic signed [33:0] res_reg [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            mag[l]     = t22_reg[l][43] ? 44'(-t22_reg[l]) : 44'(t22_reg[l]);
            hi_prod[l] = 39'(mag[l][41:23]) * 39'(M_HI);
            rh[l]      = 7'(xh23_reg[l] - 19'(qh23_reg[l]) * 19'd125);
            lo_prod[l] = 55'(y24_reg[l]) * 55'(M_LO);
            q_sum[l]   = {qh25_reg[l], 20'b0} + 33'(qy25_reg[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                neg23_reg[l] <= t22_reg[l][43];
                xh23_reg[l]  <= mag[l][41:23];
                xl23_reg[l]  <= mag[l][22:3];
                qh23_reg[l]  <= hi_prod[l][K_HI +: 13];
                neg24_reg[l] <= neg23_reg[l];
                qh24_reg[l]  <= qh23_reg[l];
                y24_reg[l]   <= {rh[l], xl23_reg[l]};
                neg25_reg[l] <= neg24_reg[l];
                qh25_reg[l]  <= qh24_reg[l];
                qy25_reg[l]  <= lo_prod[l][K_LO +: 20];
                res_reg[l]   <= neg25_reg[l] ? -$signed({1'b0, q_sum[l]})
                                             :  $signed({1'b0, q_sum[l]});
            end
        end
    end

    assign rotated_first  = res_reg[0];
    assign rotated_second = res_reg[1];

    // ---------------- checks ----------------
    a_angle_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> a5_reg < 13'(TWO_PI))
        else $error("reduced angle out of range");

    a_cos_angle_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[5] |-> ac6_reg < 13'(TWO_PI))
        else $error("cosine angle out of range");

    a_sine_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[19] |-> (dv_q_reg[DIV_BITS][0] <= 11'd1000)
                        && (dv_q_reg[DIV_BITS][1] <= 11'd1000))
        else $error("kernel quotient above unit scale");

endmodule

>>> dv/tb_rotary_pair_rotation_unit.sv
// Testbench for the rotary pair rotation unit: directed and random pairs checked against a predictor.
module tb_rotary_pair_rotation_unit
    import rpr_pkg::*;
();

    // Expected rotated pair, queued in transfer order.
    typedef struct {
        logic signed [33:0] first;
        logic signed [33:0] second;
    } rot_pair_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [19:0]        position;
    logic [15:0]        rate_mrad;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic               out_valid;
    logic               out_ready;
    logic signed [33:0] rotated_first;
    logic signed [33:0] rotated_second;

    rot_pair_t   expected_pairs[$];
    int unsigned mismatch_count;
    int unsigned idle_cycles;
    bit          idle_enable;    // random stalls on both sides when set
    bit          hold_off;       // receiver long hold-off request
    bit          timed_out;

    localparam int unsigned LATENCY     = 26;
    localparam int unsigned WATCH_LIMIT = 5000;

    rotary_pair_rotation_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .position       (position),
        .rate_mrad      (rate_mrad),
        .first_value    (first_value),
        .second_value   (second_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rotated_first  (rotated_first),
        .rotated_second (rotated_second)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Bhaskara I sine for a folded angle 0..1571, scaled by 1000.
    function automatic longint bhaskara_sine(longint x);
        longint px;
        longint den;
        px  = x * (longint'(PI_MR) - x);
        den = 5 * 64'sd3142 * 64'sd3142 - 4 * px;
        if (den == 0)
            return 0;
        return (16 * px * 1000) / den;
    endfunction

    // Fold a reduced angle 0..6282 onto the first quadrant.
    function automatic longint quadrant_sine(longint a);
        if (a <= HALF_PI)
            return bhaskara_sine(a);
        if (a <= PI_MR)
            return bhaskara_sine(PI_MR - a);
        if (a <= PI_MR + HALF_PI)
            return -bhaskara_sine(a - PI_MR);
        return -bhaskara_sine(TWO_PI - a);
    endfunction

    function automatic rot_pair_t rotate_pair(logic [19:0] pos, logic [15:0] rate,
                                              logic signed [31:0] x0,
                                              logic signed [31:0] x1);
        rot_pair_t r;
        longint angle;
        longint s;
        longint c;
        longint p0;
        longint p1;
        angle = (longint'(pos) * longint'(rate)) % TWO_PI;
        s     = quadrant_sine(angle);
        c     = quadrant_sine((angle + HALF_PI) % TWO_PI);
        // SV signed division truncates toward zero
        p0 = (longint'(x0) * c - longint'(x1) * s) / 1000;
        p1 = (longint'(x0) * s + longint'(x1) * c) / 1000;
        r.first  = p0[33:0];
        r.second = p1[33:0];
        return r;
    endfunction

    // Offer one pair and wait for its transfer; predict on acceptance.
    // Valid drops only during an idle gap, so back-to-back pairs keep it high.
    task automatic send_pair(logic [19:0] pos, logic [15:0] rate,
                             logic signed [31:0] x0, logic signed [31:0] x1);
        while (idle_enable && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        position     <= pos;
        rate_mrad    <= rate;
        first_value  <= x0;
        second_value <= x1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_pairs.push_back(rotate_pair(pos, rate, x0, x1));
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed(32'($urandom_range(2000))) - 32'sd1000;
            default: return $signed($urandom);
        endcase
    endfunction

    // Receiver side: random stalls, plus the long hold-off when asked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= !(idle_enable && $urandom_range(99) < 7);
    end

    // Result checker: compare every output transfer with the oldest prediction.
    always @(posedge clk)
    begin
        rot_pair_t exp_pair;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pairs.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %0d %0d", rotated_first, rotated_second);
            end
            else
            begin
                exp_pair = expected_pairs.pop_front();
                if (exp_pair.first !== rotated_first || exp_pair.second !== rotated_second)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %0d %0d got %0d %0d", exp_pair.first,
                                 exp_pair.second, rotated_first, rotated_second);
                end
            end
        end
    end

    // Watchdog: cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            timed_out = 1'b1;
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Extremes of every field and the quadrant boundaries of the angle.
    task automatic test_directed();
        send_pair(20'd0, 16'd0, 32'sd1000, 32'sd0);
        send_pair(20'hFFFFF, 16'hFFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_pair(20'hFFFFF, 16'hFFFF, 32'sh8000_0000, 32'sh8000_0000);
        send_pair(20'd1, 16'd1571, 32'sd1000, 32'sd2000);
        send_pair(20'd1, 16'd1572, 32'sd1000, -32'sd2000);
        send_pair(20'd1, 16'd3142, -32'sd1000, 32'sd500);
        send_pair(20'd1, 16'd3143, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_pair(20'd1, 16'd4713, 32'sd12345, 32'sd999);
        send_pair(20'd1, 16'd4714, -32'sd1, 32'sd1);
        send_pair(20'd1, 16'd6282, 32'sd1000, 32'sd1000);
        send_pair(20'd1, 16'd6283, 32'sd1000, 32'sd1000);
        send_pair(20'd3, 16'd2094, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_pair(20'hAAAAA, 16'h5555, -32'sd7, 32'sd3);
        send_pair(20'h55555, 16'hAAAA, 32'shAAAA_AAAA, 32'sh5555_5555);
    endtask

    // Random pairs; the first stretch runs without any idling.
    task automatic test_random(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            idle_enable = (i >= 300);
            if ($urandom_range(3) == 0)
                send_pair(20'($urandom_range(15)), 16'($urandom_range(6300)),
                          rand_value(), rand_value());
            else
                send_pair(20'($urandom), 16'($urandom), rand_value(), rand_value());
        end
    endtask

    // Receiver holds off while the sender keeps offering, so the pipe fills.
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (80)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 60; i++)
                send_pair(20'($urandom), 16'($urandom), rand_value(), rand_value());
        join
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        position       = '0;
        rate_mrad      = '0;
        first_value    = '0;
        second_value   = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        idle_enable    = 1'b0;
        hold_off       = 1'b0;
        timed_out      = 1'b0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(800);
        test_backpressure();
        test_random(780);
        in_valid <= 1'b0;

        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
